### hw/rtl/keyframe_polyline_decimator_unit_defines.svh
// assertion macros used by keyframe_polyline_decimator_unit.sv
`ifndef KEYFRAME_POLYLINE_DECIMATOR_UNIT_DEFINES_SVH
`define KEYFRAME_POLYLINE_DECIMATOR_UNIT_DEFINES_SVH
`define KPD_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define KPD_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

### hw/rtl/kpd_pkg.sv
`default_nettype none
package kpd_pkg;
  localparam int MaxKeysDefault = 64;
  localparam int TimeW = 16;
  localparam int ValueW = 32;
  localparam int TolW = 31;
  localparam int FracW = 17;
  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [0:0] RegTolerance = 1'b0;
  localparam logic [0:0] RegInterpMode = 1'b1;
endpackage
`default_nettype wire

### hw/rtl/kpd_divider.sv
`default_nettype none
module kpd_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q;
  logic [16:0] r;
  logic [15:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] sh;

  always_comb begin
    sh = {r[15:0], q[31]};
    trial = sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      q <= dividend;
      r <= '0;
      d <= divisor;
      cnt <= 6'd32;
    end else if (busy) begin
      if (!trial[16]) begin
        r <= trial;
        q <= {q[30:0], 1'b1};
      end else begin
        r <= sh;
        q <= {q[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = q;
endmodule
`default_nettype wire

### hw/rtl/kpd_key_store.sv
`default_nettype none
module kpd_key_store #(
  parameter int MAX_KEYS = kpd_pkg::MaxKeysDefault,
  parameter int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [IdxW-1:0]           waddr,
  input  wire logic [kpd_pkg::TimeW-1:0] wtime,
  input  wire logic [31:0]               wvalue,
  input  wire logic [IdxW-1:0]           raddr,
  output logic [kpd_pkg::TimeW-1:0]      rtime,
  output logic [31:0]                    rvalue
);
  logic [kpd_pkg::TimeW-1:0] time_mem [MAX_KEYS];
  logic [31:0]               value_mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      value_mem[waddr] <= wvalue;
    end
    rtime <= time_mem[raddr];
    rvalue <= value_mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/keyframe_polyline_decimator_unit.sv
// flow: a non-final key is taken while loading; after the last key each segment pops its
// bounds from the stack and reads both end keys from the store, and each interior key
// takes one store read, a 32-step shift-subtract divider, three multiply stages and a
// compare, with the divider skipped where the fraction clamps
// output: kept keys are emitted in order, each held until out_ready, and dropped keys
// are skipped; sequential, one set at a time
// reset: synchronous rst clears control, key count, keep marks and registers
`default_nettype none
`include "keyframe_polyline_decimator_unit_defines.svh"
module keyframe_polyline_decimator_unit #(
  parameter int MAX_KEYS = kpd_pkg::MaxKeysDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:2]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [15:0]          key_time,
  input  wire logic signed [31:0]   key_value,
  input  wire logic                 last_key,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               kept_time,
  output logic signed [31:0]        kept_value,
  output logic                      last_kept,
  output logic                      overflow
);
  localparam int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CntW = $clog2(MAX_KEYS + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_POP, S_POPW, S_RDS, S_RDE, S_ITER, S_RDI, S_LATI,
    S_DIV, S_DWAIT, S_M1, S_M2, S_M3, S_M4, S_CMP, S_DONE, S_EM_RD, S_EM_LAT, S_EM_OUT
  } state_t;

  state_t state;
  logic [kpd_pkg::TolW-1:0] tolerance;
  logic interp_mode;
  logic [CntW-1:0] key_count;
  logic overflow_seen;
  logic [MAX_KEYS-1:0] keep_marks;
  logic [2*IdxW-1:0] stack_mem [MAX_KEYS];
  logic [2*IdxW-1:0] stack_rd;
  logic [CntW-1:0] sp;
  logic [IdxW-1:0] seg_s, seg_e, cur, far;
  logic [31:0] best;
  logic found;
  logic [15:0] ts, te, ti;
  logic signed [31:0] vs, ve, vi;
  logic [16:0] frac;
  logic [33:0] f2;
  logic [33:0] sfac;
  logic signed [50:0] prod;
  logic signed [50:0] vdiff, sfac_ext;
  logic signed [33:0] dev_raw;
  logic [33:0] dev_abs;
  logic [31:0] dev_sat;
  logic [CntW-1:0] total, emitted;
  logic st_we;
  logic [IdxW-1:0] st_waddr;
  logic [IdxW-1:0] raddr;
  logic [15:0] rtime;
  logic [31:0] rvalue;
  logic div_start, div_done;
  logic [31:0] div_q;
  logic [31:0] div_num;
  logic [15:0] div_den;
  logic push_two;
  logic accept;
  logic [CntW-1:0] kc_last;

  assign pready = 1'b1;
  assign prdata = (paddr == kpd_pkg::RegTolerance) ? {1'b0, tolerance} : {31'd0, interp_mode};
  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_LOAD);
  assign st_we = accept && (key_count < CntW'(MAX_KEYS));
  assign st_waddr = key_count[IdxW-1:0];
  assign kc_last = key_count - CntW'(1);

  kpd_key_store #(.MAX_KEYS(MAX_KEYS), .IdxW(IdxW)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wtime(key_time), .wvalue(key_value),
    .raddr(raddr), .rtime(rtime), .rvalue(rvalue)
  );

  assign div_num = {ti - ts, 16'd0};
  assign div_den = te - ts;
  kpd_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    raddr = cur;
    case (state)
      S_POPW:  raddr = stack_rd[2*IdxW-1:IdxW];
      S_RDS:   raddr = seg_e;
      default: raddr = cur;
    endcase
  end

  assign vdiff = 51'(ve) - 51'(vs);
  assign sfac_ext = $signed({33'd0, sfac[17:0]});

  always_comb begin
    dev_raw = 34'(vi) - 34'(vs) - 34'(prod >>> 16);
    dev_abs = dev_raw[33] ? 34'(-dev_raw) : 34'(dev_raw);
    dev_sat = (dev_abs > 34'(kpd_pkg::SatMax)) ? kpd_pkg::SatMax : dev_abs[31:0];
  end

  assign div_start = (state == S_DIV) && (te > ts) && (ti > ts) && (ti < te);

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      stack_mem[0] <= {IdxW'(0), kc_last[IdxW-1:0]};
    end else if (state == S_CMP && found && best > {1'b0, tolerance}) begin
      stack_mem[sp[IdxW-1:0]] <= {seg_s, far};
    end else if (push_two) begin
      stack_mem[sp[IdxW-1:0] - IdxW'(1)] <= {far, seg_e};
    end
    stack_rd <= stack_mem[sp[IdxW-1:0] - IdxW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      tolerance <= '0;
      interp_mode <= 1'b0;
      key_count <= '0;
      overflow_seen <= 1'b0;
      keep_marks <= '0;
      sp <= '0;
      out_valid <= 1'b0;
      push_two <= 1'b0;
    end else begin
      push_two <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr == kpd_pkg::RegTolerance) tolerance <= pwdata[kpd_pkg::TolW-1:0];
        else interp_mode <= pwdata[0];
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (key_count < CntW'(MAX_KEYS)) key_count <= key_count + CntW'(1);
            else overflow_seen <= 1'b1;
            if (last_key) state <= S_INIT;
          end
        end
        S_INIT: begin
          if (key_count <= CntW'(2)) begin
            for (int k = 0; k < MAX_KEYS; k++)
              if (CntW'(k) < key_count) keep_marks[k] <= 1'b1;
            state <= S_DONE;
          end else begin
            keep_marks[0] <= 1'b1;
            keep_marks[kc_last[IdxW-1:0]] <= 1'b1;
            sp <= CntW'(1);
            state <= S_POP;
          end
        end
        S_POP: begin
          if (!push_two) begin
            if (sp == '0) state <= S_DONE;
            else state <= S_POPW;
          end
        end
        S_POPW: begin
          seg_s <= stack_rd[2*IdxW-1:IdxW];
          seg_e <= stack_rd[IdxW-1:0];
          sp <= sp - CntW'(1);
          state <= S_RDS;
        end
        S_RDS: begin
          ts <= rtime; vs <= rvalue;
          state <= S_RDE;
        end
        S_RDE: begin
          te <= rtime; ve <= rvalue;
          cur <= seg_s + IdxW'(1);
          best <= '0; found <= 1'b0;
          state <= S_ITER;
        end
        S_ITER: begin
          if ({1'b0, cur} >= {1'b0, seg_e}) state <= S_CMP;
          else state <= S_RDI;
        end
        S_RDI: state <= S_LATI;
        S_LATI: begin
          ti <= rtime; vi <= rvalue;
          state <= S_DIV;
        end
        S_DIV: begin
          if (te <= ts || ti <= ts) begin
            frac <= '0; state <= S_M1;
          end else if (ti >= te) begin
            frac <= 17'h10000; state <= S_M1;
          end else state <= S_DWAIT;
        end
        S_DWAIT: if (div_done) begin
          frac <= div_q[16:0]; state <= S_M1;
        end
        S_M1: begin
          f2 <= 34'(({17'd0, frac} * {17'd0, frac}) >> 16);
          state <= S_M2;
        end
        S_M2: begin
          if (interp_mode) sfac <= 34'((f2 * (34'd196608 - 34'({frac, 1'b0}))) >> 16);
          else sfac <= 34'(frac);
          state <= S_M3;
        end
        S_M3: begin
          prod <= vdiff * sfac_ext;
          state <= S_M4;
        end
        S_M4: begin
          if (dev_sat > best) begin
            best <= dev_sat; far <= cur; found <= 1'b1;
          end
          cur <= cur + IdxW'(1);
          state <= S_ITER;
        end
        S_CMP: begin
          if (found && best > {1'b0, tolerance}) begin
            keep_marks[far] <= 1'b1;
            sp <= sp + CntW'(2);
            push_two <= 1'b1;
          end
          state <= S_POP;
        end
        S_DONE: begin
          total <= CntW'($countones(keep_marks));
          emitted <= '0;
          cur <= '0;
          state <= S_EM_RD;
        end
        S_EM_RD: begin
          if ({1'b0, cur} >= key_count || emitted == total) begin
            keep_marks <= '0; key_count <= '0; overflow_seen <= 1'b0;
            state <= S_LOAD;
          end else if (keep_marks[cur]) state <= S_EM_LAT;
          else begin
            if ({1'b0, cur} == kc_last) state <= S_EM_RD;
            cur <= cur + IdxW'(1);
          end
        end
        S_EM_LAT: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (!out_valid) begin
            kept_time <= rtime; kept_value <= rvalue;
            last_kept <= (emitted + CntW'(1) == total);
            overflow <= overflow_seen;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            emitted <= emitted + CntW'(1);
            cur <= cur + IdxW'(1);
            state <= S_EM_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // stack pushes are written one per cycle: second push lands at sp-1
  `KPD_ASSERT_IMPL(a_ready_load, clk, rst, in_ready, state == S_LOAD)
  `KPD_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, key_count <= CntW'(MAX_KEYS))
  `KPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
